/* rtl/core/ssgf_pkg.sv */
// shared types for the sorted sequence gap finder
package ssgf_pkg;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;  // take the input transfer, update the expectation
		logic step;  // one missing value transferred, advance the run
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;  // the presented input opens a gap
		logic last;  // the current missing value ends the run
	} status_t;

endpackage

/* rtl/core/ssgf_ctrl.sv */
// controller state machine for the sorted sequence gap finder
module ssgf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output ssgf_pkg::cmd_t    cmd,
	input  ssgf_pkg::status_t status
);
	import ssgf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid && status.emit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				cmd.step = m_tready;
				// the closing transfer frees the input side in the same cycle
				if (m_tready && status.last) begin
					s_tready = 1'b1;
					cmd.load = s_tvalid;
					state_d  = (s_tvalid && status.emit) ? ST_EMIT : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/ssgf_dp.sv */
// datapath for the sorted sequence gap finder
module ssgf_dp #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_GAP     = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic [VALUE_WIDTH-1:0] in_value,
	input  logic                   in_start,
	output logic [VALUE_WIDTH-1:0] out_value,
	output logic                   out_last,
	output logic                   out_trunc,
	input  ssgf_pkg::cmd_t         cmd,
	output ssgf_pkg::status_t      status
);
	import ssgf_pkg::*;

	localparam int CNT_W = $clog2(MAX_GAP + 1);
	localparam logic [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] V_ONE = VALUE_WIDTH'(1);
	localparam logic [CNT_W-1:0]       C_ONE = CNT_W'(1);

	logic                   dir_q;
	logic                   have_first_q;
	logic [VALUE_WIDTH-1:0] exp_q;
	logic [VALUE_WIDTH-1:0] cur_q;
	logic [CNT_W-1:0]       rem_q;
	logic                   trunc_q;

	logic                   seed;
	logic                   hit;
	logic [VALUE_WIDTH-1:0] gap;
	logic                   gap_trunc;
	logic [CNT_W-1:0]       gap_cnt;
	logic [VALUE_WIDTH-1:0] sat_src;
	logic [VALUE_WIDTH-1:0] exp_next;

	assign seed = in_start || !have_first_q;
	assign hit  = dir_q ? ($signed(in_value) < $signed(exp_q))
	                    : ($signed(exp_q) < $signed(in_value));
	assign gap  = dir_q ? (exp_q - in_value) : (in_value - exp_q);

	assign gap_trunc = gap > VALUE_WIDTH'(MAX_GAP);
	assign gap_cnt   = gap_trunc ? CNT_W'(MAX_GAP) : gap[CNT_W-1:0];

	// out of order items advance from the old expectation
	assign sat_src = (seed || hit) ? in_value : exp_q;

	always_comb begin
		if (dir_q) begin
			exp_next = (sat_src == V_MIN) ? sat_src : sat_src - V_ONE;
		end else begin
			exp_next = (sat_src == V_MAX) ? sat_src : sat_src + V_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q        <= 1'b0;
			have_first_q <= 1'b0;
			exp_q        <= '0;
			rem_q        <= '0;
		end else begin
			if (cfg_we) begin
				dir_q <= cfg_wdata;
			end
			if (cmd.load) begin
				have_first_q <= 1'b1;
				exp_q        <= exp_next;
				rem_q        <= gap_cnt;
			end else if (cmd.step) begin
				rem_q <= rem_q - C_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q   <= exp_q;
			trunc_q <= gap_trunc;
		end else if (cmd.step) begin
			cur_q <= dir_q ? (cur_q - V_ONE) : (cur_q + V_ONE);
		end
	end

	assign out_value   = cur_q;
	assign out_last    = (rem_q == C_ONE);
	assign out_trunc   = trunc_q;
	assign status.emit = hit && !seed;
	assign status.last = out_last;

endmodule

/* rtl/core/sorted_sequence_gap_finder.sv */
// top level of the sorted sequence gap finder
// a value that opens a gap shows its first missing value in the cycle after its transfer
// inputs without a gap are taken while idle; an input that opens a gap holds off the next input
//   until its last missing value is transferred, the next input being taken in the cycle of that transfer
// the wait comes from the single run counter and the one output register in the datapath
// reset: arst_n clears direction, the expectation and the started flag at once
module sorted_sequence_gap_finder #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_GAP     = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// direction register: 0 increasing, 1 decreasing
	input  logic                                 cfg_we,
	input  logic                                 cfg_wdata,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,  // value
	input  logic                                 s_tuser,  // start_of_array
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,  // missing_value
	output logic                                 m_tlast,  // last_of_run
	output logic                                 m_tuser   // truncated
);
	import ssgf_pkg::*;

	localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

	cmd_t                   cmd;
	status_t                status;
	logic [VALUE_WIDTH-1:0] out_value;

	// controller: idle accepts inputs, emit walks through the missing values
	ssgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// datapath: expectation, gap compare and subtract, run counter
	ssgf_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_GAP     (MAX_GAP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_value  (s_tdata[VALUE_WIDTH-1:0]),
		.in_start  (s_tuser),
		.out_value (out_value),
		.out_last  (m_tlast),
		.out_trunc (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

	// pad the missing value with zeros up to whole bytes
	assign m_tdata = DATA_W'(out_value);

endmodule

/* bench/tb_sorted_sequence_gap_finder.sv */
// self-checking testbench for the sorted sequence gap finder: directed and random sequences
module tb_sorted_sequence_gap_finder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW           = 32;
	localparam int GAP_MAX      = 64;
	localparam int STALL_LIMIT  = 2000;  // cycles with no transfer on either side
	localparam int PRESS_CYCLES = 300;   // long receiver hold-off
	localparam int TAIL_CYCLES  = 8;     // settle time once nothing is expected

	localparam logic DIR_UP   = 1'b0;
	localparam logic DIR_DOWN = 1'b1;

	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -64'sd2147483648;

	// one element of the sorted input sequence
	typedef struct {
		logic [VW-1:0] value;
		logic          first;
	} seq_item_t;

	// one reported missing value
	typedef struct {
		logic [VW-1:0] value;
		logic          last;
		logic          cut;
	} gap_rec_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cfg_we    = 1'b0;
	logic          cfg_wdata = 1'b0;
	logic          s_tvalid  = 1'b0;
	logic          s_tready;
	logic [VW-1:0] s_tdata   = '0;   // value
	logic          s_tuser   = 1'b0; // start_of_array
	logic          m_tvalid;
	logic          m_tready  = 1'b0;
	logic [VW-1:0] m_tdata;          // missing_value
	logic          m_tlast;          // last_of_run
	logic          m_tuser;          // truncated

	sorted_sequence_gap_finder #(
		.VALUE_WIDTH(VW),
		.MAX_GAP    (GAP_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus waiting for the driver, missing values waiting for the block
	seq_item_t value_feed_q[$];
	gap_rec_t  missing_q[$];

	// shadow of the block: expectation, started flag, direction register
	logic signed [VW-1:0] next_expected = '0;
	logic                 seq_started   = 1'b0;
	logic                 model_dir     = DIR_UP;

	int  errors        = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  quiet_cycles  = 0;
	logic hold_go      = 1'b0;
	logic hold_done    = 1'b0;
	int  hold_left     = 0;

	// random sequence generator state, carried across phases
	logic signed [VW-1:0] gen_prev = '0;
	int                   gen_left = 0;

	function automatic logic signed [VW-1:0] inc_sat(input logic signed [VW-1:0] x);
		return (longint'(x) == VAL_MAX) ? x : x + 1;
	endfunction

	function automatic logic signed [VW-1:0] dec_sat(input logic signed [VW-1:0] x);
		return (longint'(x) == VAL_MIN) ? x : x - 1;
	endfunction

	// work out the missing values that one accepted element produces
	task automatic predict_missing(input logic signed [VW-1:0] v, input logic first);
		longint   span;
		int       count;
		logic     cut;
		gap_rec_t rec;
		// a start mark, or any element before a sequence exists, only seeds
		if (first || !seq_started) begin
			seq_started   = 1'b1;
			next_expected = (model_dir == DIR_DOWN) ? dec_sat(v) : inc_sat(v);
			return;
		end
		// duplicates and out of order elements just nudge the expectation on
		if (model_dir == DIR_UP) begin
			if (v <= next_expected) begin
				next_expected = inc_sat(next_expected);
				return;
			end
			span = longint'(v) - longint'(next_expected);
		end else begin
			if (v >= next_expected) begin
				next_expected = dec_sat(next_expected);
				return;
			end
			span = longint'(next_expected) - longint'(v);
		end
		// long gaps are cut to the first GAP_MAX values, all flagged
		cut   = (span > GAP_MAX);
		count = cut ? GAP_MAX : int'(span);
		for (int k = 0; k < count; k++) begin
			rec.value = (model_dir == DIR_DOWN) ? next_expected - k : next_expected + k;
			rec.last  = (k == count - 1);
			rec.cut   = cut;
			missing_q.push_back(rec);
		end
		next_expected = (model_dir == DIR_DOWN) ? dec_sat(v) : inc_sat(v);
	endtask

	// driver: a new element goes out once the previous transfer is done
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (value_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= value_feed_q[0].value;
					s_tuser  <= value_feed_q[0].first;
					void'(value_feed_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (hold_go && !hold_done) begin
				hold_left <= PRESS_CYCLES;
				hold_done <= 1'b1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// monitor: check each output transfer, then predict from each input transfer
	always @(posedge clk) begin
		gap_rec_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (missing_q.size() == 0) begin
					$display("%0t: unexpected transfer: expected none, got value %0d last %0b trunc %0b",
						$time, $signed(m_tdata), m_tlast, m_tuser);
					errors++;
				end else begin
					want = missing_q.pop_front();
					if (m_tdata !== want.value || m_tlast !== want.last || m_tuser !== want.cut) begin
						$display("%0t: mismatch: expected value %0d last %0b trunc %0b, got value %0d last %0b trunc %0b",
							$time, $signed(want.value), want.last, want.cut,
							$signed(m_tdata), m_tlast, m_tuser);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_missing(s_tdata, s_tuser);
		end
	end

	// watchdog: too long without any transfer means the block hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles + 1 >= STALL_LIMIT) begin
					$display("sorted_sequence_gap_finder regression: fail");
					$finish;
				end
			end
		end
	end

	task automatic add_item(input logic [VW-1:0] v, input logic first);
		seq_item_t it;
		it.value = v;
		it.first = first;
		value_feed_q.push_back(it);
	endtask

	// wait until every element went in and every missing value came out
	task automatic wait_drained();
		do @(negedge clk);
		while (value_feed_q.size() != 0 || s_tvalid || missing_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// direction write, only while the block is idle
	task automatic set_direction(input logic d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		model_dir = d;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly well-formed runs with random content, some noise and backward steps
	task automatic queue_random(input int n, input logic d);
		seq_item_t it;
		int        roll;
		longint    delta;
		longint    nv;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				// noise: any value, any start mark
				it.value = $urandom;
				it.first = 1'($urandom_range(0, 1));
			end else if (gen_left == 0) begin
				// new run, sometimes right at the ends of the range
				roll = $urandom_range(0, 99);
				if (roll < 10)
					nv = VAL_MAX - longint'($urandom_range(0, 20));
				else if (roll < 20)
					nv = VAL_MIN + longint'($urandom_range(0, 20));
				else
					nv = longint'($signed(32'($urandom)));
				it.value = nv[VW-1:0];
				it.first = 1'b1;
				gen_prev = it.value;
				gen_left = $urandom_range(3, 10);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 5)
					delta = -longint'($urandom_range(1, 5));
				else if (roll < 10)
					delta = 0;
				else if (roll < 45)
					delta = 1;
				else if (roll < 85)
					delta = longint'($urandom_range(2, 6));
				else
					delta = longint'($urandom_range(7, 80));
				nv = longint'(gen_prev) + ((d == DIR_DOWN) ? -delta : delta);
				if (nv > VAL_MAX)
					nv = VAL_MAX;
				if (nv < VAL_MIN)
					nv = VAL_MIN;
				it.value = nv[VW-1:0];
				it.first = 1'b0;
				gen_prev = it.value;
				gen_left--;
			end
			value_feed_q.push_back(it);
		end
	endtask

	initial begin
		logic phase_dir[6];
		phase_dir = '{DIR_DOWN, DIR_UP, DIR_DOWN, DIR_UP, DIR_DOWN, DIR_UP};
		send_idle_pct = 12;
		recv_idle_pct = 49;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed, increasing
		set_direction(DIR_UP);
		@(negedge clk);
		add_item(32'd10, 1'b0);          // no sequence yet: seeds anyway
		add_item(32'd11, 1'b0);          // no gap
		add_item(32'd13, 1'b0);          // single missing value
		add_item(32'd18, 1'b0);          // short run
		add_item(32'd18, 1'b0);          // out of order
		add_item(32'd20, 1'b0);          // equal to the expectation
		add_item(32'd85, 1'b0);          // exactly GAP_MAX missing, not cut
		add_item(32'd151, 1'b0);         // one past GAP_MAX, cut
		add_item(32'h8000_0000, 1'b1);   // most negative value
		add_item(32'h8000_0003, 1'b0);
		add_item(32'h7fff_fff8, 1'b1);
		add_item(32'h7fff_ffff, 1'b0);   // expectation saturates at the top
		add_item(32'h7fff_ffff, 1'b0);   // duplicate at the top stays put
		add_item(32'hffff_ffff, 1'b1);
		add_item(32'd1000, 1'b0);        // long gap
		wait_drained();

		// directed, decreasing; first element continues the old sequence
		set_direction(DIR_DOWN);
		@(negedge clk);
		add_item(32'd995, 1'b0);
		add_item(32'd994, 1'b0);
		add_item(32'd1000, 1'b0);        // out of order downward
		add_item(32'h7fff_ffff, 1'b1);
		add_item(32'h7fff_ff9b, 1'b0);   // long gap, cut
		add_item(32'h8000_0008, 1'b1);
		add_item(32'h8000_0000, 1'b0);   // expectation saturates at the bottom
		add_item(32'h8000_0000, 1'b0);
		add_item(32'd5, 1'b1);
		add_item(32'd4, 1'b0);
		wait_drained();

		// random phases with alternating direction and idling patterns
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_idle_pct = 49;
				recv_idle_pct = 12;
			end
			if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_direction(phase_dir[p]);
			// one long hold-off while the sender keeps offering
			if (p == 1) begin
				@(posedge clk);
				hold_go <= 1'b1;
			end
			@(negedge clk);
			queue_random(21, phase_dir[p]);
			wait_drained();
		end

		if (errors == 0)
			$display("sorted_sequence_gap_finder regression: pass");
		else
			$display("sorted_sequence_gap_finder regression: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ssgf_pkg.sv
rtl/core/ssgf_ctrl.sv
rtl/core/ssgf_dp.sv
rtl/core/sorted_sequence_gap_finder.sv
bench/tb_sorted_sequence_gap_finder.sv
